[design/irs_pkg.sv]
// Package for the indexed ring sequence unit.
// Holds default sizes, field widths, operation and status codes.
// No dependencies.
package irs_pkg;

    localparam int CAPACITY_DEF    = 256;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int FUNC_W  = 4;
    localparam int POS_W   = 10;
    localparam int RVAL_W  = 32;
    localparam int IVAL_W  = 32;
    localparam int COUNT_W = 9;
    localparam int STAT_W  = 2;

    localparam logic [FUNC_W-1:0] FN_GET    = 4'd0;
    localparam logic [FUNC_W-1:0] FN_PUT    = 4'd1;
    localparam logic [FUNC_W-1:0] FN_ADD    = 4'd2;
    localparam logic [FUNC_W-1:0] FN_ADDLO  = 4'd3;
    localparam logic [FUNC_W-1:0] FN_ADDHI  = 4'd4;
    localparam logic [FUNC_W-1:0] FN_REMOVE = 4'd5;
    localparam logic [FUNC_W-1:0] FN_RMLO   = 4'd6;
    localparam logic [FUNC_W-1:0] FN_RMHI   = 4'd7;
    localparam logic [FUNC_W-1:0] FN_ROTATE = 4'd8;
    localparam logic [FUNC_W-1:0] FN_CLEAR  = 4'd9;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

endpackage

[design/irs_if.sv]
// Request and response channel interfaces for the indexed ring sequence unit.
// Depends on irs_pkg.
interface irs_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [irs_pkg::FUNC_W-1:0]   func;
    logic signed [irs_pkg::POS_W-1:0] position;
    logic [irs_pkg::IVAL_W-1:0]   item_value;

    modport source (output valid, func, position, item_value, input ready);
    modport sink   (input valid, func, position, item_value, output ready);
endinterface

interface irs_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [irs_pkg::RVAL_W-1:0]   read_value;
    logic [irs_pkg::COUNT_W-1:0]  count_now;
    logic [irs_pkg::STAT_W-1:0]   status;

    modport source (output valid, read_value, count_now, status, input ready);
    modport sink   (input valid, read_value, count_now, status, output ready);
endinterface

[design/irs_ram.sv]
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
module irs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[design/indexed_ring_sequence_unit.sv]
// Indexed ring sequence unit: bounded circular deque over one RAM.
// Depends on irs_pkg, irs_if (irs_cmd_if, irs_rsp_if) and irs_ram.
//
//   channel  dir  handshake    payload
//   cmd      in   valid/ready  func, position, item_value
//   rsp      out  valid/ready  read_value, count_now, status
//
// One request at a time; get, put, add/remove at the ends, rotate and clear
// pass through decode, a RAM read wait where needed, and finish. Middle
// add/remove runs one RAM move a cycle through the single read and write port.
// Reset empties the ring; the RAM is not cleared. A held response does not
// block the next request; the result of that request waits for it, and ready
// stays low meanwhile.
module indexed_ring_sequence_unit #(
    parameter int CAPACITY    = irs_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = irs_pkg::VALUE_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    irs_cmd_if.sink   cmd,
    irs_rsp_if.source rsp
);
    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = ((CW > irs_pkg::POS_W) ? CW : irs_pkg::POS_W) + 2;
    localparam int VW = VALUE_WIDTH;

    typedef enum logic [2:0] {
        ST_IDLE, ST_DECODE, ST_RDWAIT, ST_SHIFT, ST_INSWR, ST_FINISH
    } state_t;

    state_t                     state_reg, state_next;
    logic [irs_pkg::FUNC_W-1:0] op_reg, op_next;
    logic signed [irs_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [VW-1:0]              val_reg, val_next;
    logic [AW-1:0]              head_reg, head_next;
    logic [CW-1:0]              count_reg, count_next;
    logic [CW-1:0]              k_reg, k_next;
    logic [CW-1:0]              idx_reg, idx_next;
    logic [VW-1:0]              rv_reg, rv_next;
    logic [irs_pkg::STAT_W-1:0] st_reg, st_next;
    logic                       pend_reg, pend_next;
    logic [AW-1:0]              paddr_reg, paddr_next;
    logic                       ovalid_reg, ovalid_next;
    logic [irs_pkg::RVAL_W-1:0] orv_reg, orv_next;
    logic [irs_pkg::COUNT_W-1:0] ocnt_reg, ocnt_next;
    logic [irs_pkg::STAT_W-1:0] ost_reg, ost_next;

    logic                       dwe;
    logic [AW-1:0]              dwaddr;
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [VW-1:0]              ram_wdata;
    logic [AW-1:0]              ram_raddr;
    logic [VW-1:0]              ram_q;

    logic signed [PW-1:0]       p;
    logic signed [PW-1:0]       len;
    logic                       full;

    function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] k);
        logic [CW:0] sum;
        sum = (CW+1)'(h) + (CW+1)'(k);
        if (sum >= (CW+1)'(CAPACITY))
        begin
            sum = sum - (CW+1)'(CAPACITY);
        end
        return AW'(sum);
    endfunction

    function automatic logic [AW-1:0] head_dec(input logic [AW-1:0] h);
        return (h == '0) ? AW'(CAPACITY - 1) : AW'(h - 1'b1);
    endfunction

    function automatic logic [AW-1:0] head_inc(input logic [AW-1:0] h);
        return (h == AW'(CAPACITY - 1)) ? '0 : AW'(h + 1'b1);
    endfunction

    irs_ram #(
        .WIDTH (VW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_q)
    );

    assign p    = PW'(pos_reg);
    assign len  = signed'(PW'(count_reg));
    assign full = (count_reg >= CW'(CAPACITY));

    assign cmd.ready      = (state_reg == ST_IDLE);
    assign rsp.valid      = ovalid_reg;
    assign rsp.read_value = orv_reg;
    assign rsp.count_now  = ocnt_reg;
    assign rsp.status     = ost_reg;

    assign ram_we    = pend_reg | dwe;
    assign ram_waddr = pend_reg ? paddr_reg : dwaddr;
    assign ram_wdata = pend_reg ? ram_q : val_reg;

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        k_next      = k_reg;
        idx_next    = idx_reg;
        rv_next     = rv_reg;
        st_next     = st_reg;
        pend_next   = 1'b0;
        paddr_next  = paddr_reg;
        ovalid_next = ovalid_reg;
        orv_next    = orv_reg;
        ocnt_next   = ocnt_reg;
        ost_next    = ost_reg;
        dwe         = 1'b0;
        dwaddr      = slot(head_reg, k_reg);
        ram_raddr   = slot(head_reg, k_reg);

        if (ovalid_reg && rsp.ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    op_next    = cmd.func;
                    pos_next   = cmd.position;
                    val_next   = VW'(cmd.item_value);
                    rv_next    = '0;
                    st_next    = irs_pkg::ST_OK;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = ST_FINISH;
                case (op_reg)
                    irs_pkg::FN_GET, irs_pkg::FN_PUT, irs_pkg::FN_REMOVE:
                    begin
                        if (count_reg == '0)
                        begin
                            st_next = irs_pkg::ST_EMPTY;
                        end
                        else if (p < 0 || p >= len)
                        begin
                            st_next = irs_pkg::ST_BADPOS;
                        end
                        else
                        begin
                            ram_raddr  = slot(head_reg, CW'(p));
                            k_next     = CW'(p);
                            state_next = ST_RDWAIT;
                        end
                    end
                    irs_pkg::FN_ADD:
                    begin
                        if (p < -len || p > len + 1)
                        begin
                            st_next = irs_pkg::ST_BADPOS;
                        end
                        else if (full)
                        begin
                            st_next = irs_pkg::ST_FULL;
                        end
                        else
                        begin
                            rv_next = val_reg;
                            if (p == 1 || p == -len)
                            begin
                                head_next  = head_dec(head_reg);
                                dwe        = 1'b1;
                                dwaddr     = head_dec(head_reg);
                                count_next = count_reg + 1'b1;
                            end
                            else if (p == 0 || p == len + 1)
                            begin
                                dwe        = 1'b1;
                                dwaddr     = slot(head_reg, count_reg);
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                k_next     = count_reg;
                                idx_next   = (p < 0) ? CW'(p + len) : CW'(p - 1);
                                state_next = ST_SHIFT;
                            end
                        end
                    end
                    irs_pkg::FN_ADDLO, irs_pkg::FN_ADDHI:
                    begin
                        if (full)
                        begin
                            st_next = irs_pkg::ST_FULL;
                        end
                        else
                        begin
                            rv_next    = val_reg;
                            dwe        = 1'b1;
                            count_next = count_reg + 1'b1;
                            if (op_reg == irs_pkg::FN_ADDLO)
                            begin
                                head_next = head_dec(head_reg);
                                dwaddr    = head_dec(head_reg);
                            end
                            else
                            begin
                                dwaddr = slot(head_reg, count_reg);
                            end
                        end
                    end
                    irs_pkg::FN_RMLO, irs_pkg::FN_RMHI:
                    begin
                        if (count_reg == '0)
                        begin
                            st_next = irs_pkg::ST_EMPTY;
                        end
                        else
                        begin
                            ram_raddr  = (op_reg == irs_pkg::FN_RMLO) ? head_reg :
                                         slot(head_reg, CW'(count_reg - 1'b1));
                            state_next = ST_RDWAIT;
                        end
                    end
                    irs_pkg::FN_ROTATE:
                    begin
                        if (count_reg != '0)
                        begin
                            if (p < -len || p > len)
                            begin
                                st_next = irs_pkg::ST_BADPOS;
                            end
                            else if (p < 0)
                            begin
                                head_next = slot(head_reg, CW'(p + len));
                            end
                            else if (p != len)
                            begin
                                head_next = slot(head_reg, CW'(p));
                            end
                        end
                    end
                    irs_pkg::FN_CLEAR:
                    begin
                        count_next = '0;
                        head_next  = '0;
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_RDWAIT:
            begin
                rv_next    = ram_q;
                state_next = ST_FINISH;
                case (op_reg)
                    irs_pkg::FN_PUT:
                    begin
                        dwe    = 1'b1;
                        dwaddr = slot(head_reg, k_reg);
                    end
                    irs_pkg::FN_REMOVE:
                    begin
                        state_next = ST_SHIFT;
                    end
                    irs_pkg::FN_RMLO:
                    begin
                        head_next  = head_inc(head_reg);
                        count_next = count_reg - 1'b1;
                    end
                    irs_pkg::FN_RMHI:
                    begin
                        count_next = count_reg - 1'b1;
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_SHIFT:
            begin
                if (op_reg == irs_pkg::FN_REMOVE)
                begin
                    if ((CW+1)'(k_reg) + 1'b1 < (CW+1)'(count_reg))
                    begin
                        ram_raddr  = slot(head_reg, CW'(k_reg + 1'b1));
                        pend_next  = 1'b1;
                        paddr_next = slot(head_reg, k_reg);
                        k_next     = k_reg + 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                        state_next = ST_FINISH;
                    end
                end
                else
                begin
                    if (k_reg > idx_reg)
                    begin
                        ram_raddr  = slot(head_reg, CW'(k_reg - 1'b1));
                        pend_next  = 1'b1;
                        paddr_next = slot(head_reg, k_reg);
                        k_next     = k_reg - 1'b1;
                    end
                    else
                    begin
                        state_next = ST_INSWR;
                    end
                end
            end
            ST_INSWR:
            begin
                dwe        = 1'b1;
                dwaddr     = slot(head_reg, idx_reg);
                count_next = count_reg + 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!ovalid_reg || rsp.ready)
                begin
                    ovalid_next = 1'b1;
                    orv_next    = irs_pkg::RVAL_W'(rv_reg);
                    ocnt_next   = irs_pkg::COUNT_W'(count_reg);
                    ost_next    = st_reg;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            head_reg   <= '0;
            count_reg  <= '0;
            pend_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            count_reg  <= count_next;
            pend_reg   <= pend_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        pos_reg   <= pos_next;
        val_reg   <= val_next;
        k_reg     <= k_next;
        idx_reg   <= idx_next;
        rv_reg    <= rv_next;
        st_reg    <= st_next;
        paddr_reg <= paddr_next;
        orv_reg   <= orv_next;
        ocnt_reg  <= ocnt_next;
        ost_reg   <= ost_next;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> !ram_we)
        else $error("store written while idle");

    a_pend_in_shift: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> state_reg == ST_SHIFT)
        else $error("pending move outside shift");

    a_accept_decode: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.ready |=> state_reg == ST_DECODE)
        else $error("accepted request not decoded");

    a_rsp_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(ovalid_reg) |-> $past(state_reg) == ST_FINISH)
        else $error("response raised outside finish");
endmodule
